// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the vector pair similarity checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, off while reset is held
`define VPS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// next-cycle implication that also covers reset cycles
`define VPS_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/vps_pkg.sv -----
// ----------------------------------------------------------------------------
// vps_pkg
// Beat types, control groups and fixed field constants of the vector pair
// similarity block.
// ----------------------------------------------------------------------------
package vps_pkg;

    // fixed field widths of the channel beats
    localparam int ELEM_FIELD_W  = 16;
    localparam int DOT_FIELD_W   = 40;
    localparam int ROOT_FIELD_W  = 20;
    localparam int COS_FIELD_W   = 16;

    // cosine in q1.15 and its clip limits
    localparam int COS_FRAC_BITS = 15;
    localparam logic [COS_FIELD_W:0] COS_POS_MAX = 17'd32767;
    localparam logic [COS_FIELD_W:0] COS_NEG_MAX = 17'd32768;
    localparam logic [COS_FIELD_W:0] COS_SAT     = 17'd65536;

    // input beat
    typedef struct packed {
        logic signed [ELEM_FIELD_W-1:0] a_elem;
        logic signed [ELEM_FIELD_W-1:0] b_elem;
        logic                           last;
    } vps_in_t;

    // result beat
    typedef struct packed {
        logic signed [DOT_FIELD_W-1:0]  dot_product;
        logic        [ROOT_FIELD_W-1:0] distance;
        logic        [ROOT_FIELD_W-1:0] length_a;
        logic        [ROOT_FIELD_W-1:0] length_b;
        logic signed [COS_FIELD_W-1:0]  cosine;
        logic                           overflow;
    } vps_out_t;

    // accumulator control
    typedef struct packed {
        logic start;
        logic clear;
    } vps_mac_ctl_t;

    // finishing sequencer control
    typedef struct packed {
        logic start;
        logic ack;
    } vps_post_ctl_t;

endpackage

// ----- rtl/vector_pair_similarity.sv -----
// A new pair is accepted only once the previous one is through the 4-step pass of the shared
// multiplier plus its product register; a pair past MAX_LEN skips that pass and is dropped.
// The last pair then runs the shift-add product, four root passes of SQ_W steps each and the
// bit-serial divide, where SQ_W = 2*ELEM_BITS - 1 + clog2(MAX_LEN).
// The result then waits in an output register.
// Reset is synchronous, active low: the accumulator sums, the pair count and the handshake state clear.
// ----------------------------------------------------------------------------
// vector_pair_similarity
// Streams element pairs, accumulates dot product and square sums, and on the
// last pair returns lengths, distance and q1.15 cosine.
// ----------------------------------------------------------------------------
module vector_pair_similarity #(
    parameter int MAX_LEN   = 256,
    parameter int ELEM_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vps_pkg::vps_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vps_pkg::vps_out_t m_data
);

    localparam int LEN_W = $clog2(MAX_LEN);
    localparam int DOT_W = 2 * ELEM_BITS + LEN_W;
    localparam int SQ_W  = 2 * ELEM_BITS - 1 + LEN_W;
    localparam int DSQ_W = 2 * ELEM_BITS + 1 + LEN_W;
    localparam int FLD_X = (ELEM_BITS > vps_pkg::ELEM_FIELD_W) ? ELEM_BITS
                                                                : vps_pkg::ELEM_FIELD_W;
    localparam int DOT_X = (DOT_W > vps_pkg::DOT_FIELD_W) ? DOT_W : vps_pkg::DOT_FIELD_W;
    localparam int RT_X  = (SQ_W > vps_pkg::ROOT_FIELD_W) ? SQ_W : vps_pkg::ROOT_FIELD_W;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_ACC  = 3'b010,
        T_POST = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;

    logic              last_reg;
    logic              m_valid_reg;
    vps_pkg::vps_out_t m_data_reg;

    logic                    accept;
    logic                    load_out;
    logic [FLD_X-1:0]        a_x;
    logic [FLD_X-1:0]        b_x;
    logic signed [ELEM_BITS-1:0] a_in;
    logic signed [ELEM_BITS-1:0] b_in;

    vps_pkg::vps_mac_ctl_t   mac_ctl;
    vps_pkg::vps_post_ctl_t  post_ctl;
    logic                    mac_done;
    logic signed [DOT_W-1:0] dot;
    logic [SQ_W-1:0]         sum_a;
    logic [SQ_W-1:0]         sum_b;
    logic [DSQ_W-1:0]        sum_d;
    logic                    too_long;
    logic                    post_done;
    logic [SQ_W-1:0]         dist_root;
    logic [SQ_W-1:0]         len_a;
    logic [SQ_W-1:0]         len_b;
    logic signed [vps_pkg::COS_FIELD_W-1:0] cosine;

    logic signed [DOT_X-1:0] dot_x;
    logic [RT_X-1:0]         dist_x;
    logic [RT_X-1:0]         len_a_x;
    logic [RT_X-1:0]         len_b_x;

    // element sign taken from the low ELEM_BITS bits of each field
    assign a_x  = FLD_X'($unsigned(s_data.a_elem));
    assign b_x  = FLD_X'($unsigned(s_data.b_elem));
    assign a_in = signed'(a_x[ELEM_BITS-1:0]);
    assign b_in = signed'(b_x[ELEM_BITS-1:0]);

    assign s_ready  = (state_reg == T_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == T_POST) && post_done && (!m_valid_reg || m_ready);

    assign mac_ctl.start  = accept;
    assign mac_ctl.clear  = load_out;
    assign post_ctl.start = (state_reg == T_ACC) && mac_done && last_reg;
    assign post_ctl.ack   = load_out;

    vps_mac #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS),
        .DOT_W     (DOT_W),
        .SQ_W      (SQ_W),
        .DSQ_W     (DSQ_W)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .a_in     (a_in),
        .b_in     (b_in),
        .done     (mac_done),
        .dot      (dot),
        .sum_a    (sum_a),
        .sum_b    (sum_b),
        .sum_d    (sum_d),
        .too_long (too_long)
    );

    vps_post #(
        .DOT_W (DOT_W),
        .SQ_W  (SQ_W),
        .DSQ_W (DSQ_W)
    ) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (post_ctl),
        .dot       (dot),
        .sum_a     (sum_a),
        .sum_b     (sum_b),
        .sum_d     (sum_d),
        .done      (post_done),
        .dist_root (dist_root),
        .len_a     (len_a),
        .len_b     (len_b),
        .cosine    (cosine)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: if (accept) state_next = T_ACC;
            T_ACC: begin
                if (mac_done) state_next = last_reg ? T_POST : T_IDLE;
            end
            T_POST: if (load_out) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result fields fitted to the beat widths
    assign dot_x   = DOT_X'(dot);
    assign dist_x  = RT_X'(dist_root);
    assign len_a_x = RT_X'(len_a);
    assign len_b_x = RT_X'(len_b);

    // beat capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= s_data.last;
        end
        if (load_out) begin
            m_data_reg.dot_product <= signed'(dot_x[vps_pkg::DOT_FIELD_W-1:0]);
            m_data_reg.distance    <= dist_x[vps_pkg::ROOT_FIELD_W-1:0];
            m_data_reg.length_a    <= len_a_x[vps_pkg::ROOT_FIELD_W-1:0];
            m_data_reg.length_b    <= len_b_x[vps_pkg::ROOT_FIELD_W-1:0];
            m_data_reg.cosine      <= cosine;
            m_data_reg.overflow    <= too_long;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/vps_mac.sv -----
// ----------------------------------------------------------------------------
// vps_mac
// Pair accumulator: one shared signed multiplier computes a*b, a*a, b*b and
// (a-b)^2 in turn, each product registered and then added to its sum.
// ----------------------------------------------------------------------------
module vps_mac #(
    parameter int MAX_LEN   = 256,
    parameter int ELEM_BITS = 16,
    parameter int DOT_W     = 40,
    parameter int SQ_W      = 39,
    parameter int DSQ_W     = 41
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  vps_pkg::vps_mac_ctl_t   ctl,
    input  logic signed [ELEM_BITS-1:0] a_in,
    input  logic signed [ELEM_BITS-1:0] b_in,
    output logic                    done,
    output logic signed [DOT_W-1:0] dot,
    output logic [SQ_W-1:0]         sum_a,
    output logic [SQ_W-1:0]         sum_b,
    output logic [DSQ_W-1:0]        sum_d,
    output logic                    too_long
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int OP_W  = ELEM_BITS + 1;
    localparam int PR_W  = 2 * OP_W;

    // multiplier steps
    localparam logic [2:0] ST_AB    = 3'd0;
    localparam logic [2:0] ST_AA    = 3'd1;
    localparam logic [2:0] ST_BB    = 3'd2;
    localparam logic [2:0] ST_DD    = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic                    busy_reg;
    logic [2:0]              step_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    too_long_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [SQ_W-1:0]         sum_a_reg;
    logic [SQ_W-1:0]         sum_b_reg;
    logic [DSQ_W-1:0]        sum_d_reg;

    logic signed [ELEM_BITS-1:0] a_reg;
    logic signed [ELEM_BITS-1:0] b_reg;
    logic signed [OP_W-1:0]      diff;
    logic signed [OP_W-1:0]      mul_x;
    logic signed [OP_W-1:0]      mul_y;
    logic signed [PR_W-1:0]      prod_reg;
    logic                        room;

    assign room = count_reg < CNT_W'(MAX_LEN);
    assign diff = OP_W'(a_reg) - OP_W'(b_reg);

    // operand select for the shared multiplier
    always_comb begin
        unique case (step_reg)
            ST_AB: begin
                mul_x = OP_W'(a_reg);
                mul_y = OP_W'(b_reg);
            end
            ST_AA: begin
                mul_x = OP_W'(a_reg);
                mul_y = OP_W'(a_reg);
            end
            ST_BB: begin
                mul_x = OP_W'(b_reg);
                mul_y = OP_W'(b_reg);
            end
            default: begin
                mul_x = diff;
                mul_y = diff;
            end
        endcase
    end

    // sequencing and sums, cleared by reset and after each result
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            busy_reg     <= 1'b0;
            step_reg     <= ST_AB;
            done_reg     <= 1'b0;
            count_reg    <= '0;
            too_long_reg <= 1'b0;
            dot_reg      <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            sum_d_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                if (room) begin
                    busy_reg <= 1'b1;
                    step_reg <= ST_AB;
                end else begin
                    // pair past the limit is dropped
                    too_long_reg <= 1'b1;
                    done_reg     <= 1'b1;
                end
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                case (step_reg)
                    ST_AA:    dot_reg   <= dot_reg + DOT_W'(prod_reg);
                    ST_BB:    sum_a_reg <= sum_a_reg + SQ_W'(prod_reg);
                    ST_DD:    sum_b_reg <= sum_b_reg + SQ_W'(prod_reg);
                    ST_FLUSH: begin
                        sum_d_reg <= sum_d_reg + DSQ_W'(prod_reg);
                        count_reg <= count_reg + 1'b1;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // operand capture and product register
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
        if (busy_reg) begin
            prod_reg <= mul_x * mul_y;
        end
    end

    assign done     = done_reg;
    assign dot      = dot_reg;
    assign sum_a    = sum_a_reg;
    assign sum_b    = sum_b_reg;
    assign sum_d    = sum_d_reg;
    assign too_long = too_long_reg;

endmodule

// ----- rtl/vps_isqrt.sv -----
// ----------------------------------------------------------------------------
// vps_isqrt
// Floor square root, restoring digit method, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vps_isqrt #(
    parameter int RT_W  = 39,
    parameter int RAD_W = 78
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [RAD_W-1:0] radicand,
    output logic             done,
    output logic [RT_W-1:0]  root
);

    localparam int CNT_W = $clog2(RT_W + 1);
    localparam int RM_W  = RT_W + 3;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [RM_W-1:0]  rem_reg;
    logic [RT_W-1:0]  root_reg;

    logic [RM_W-1:0]  rem_sh;
    logic [RM_W-1:0]  trial;
    logic             fits;

    // one digit step
    assign rem_sh = {rem_reg[RM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = RM_W'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CNT_W'(RT_W);
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RT_W-2:0], fits};
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/vps_post.sv -----
// ----------------------------------------------------------------------------
// vps_post
// Finishing sequencer: shift-add product of the two square sums, four roots
// on one shared root unit, then a bit-serial q1.15 cosine division.
// ----------------------------------------------------------------------------
module vps_post #(
    parameter int DOT_W = 40,
    parameter int SQ_W  = 39,
    parameter int DSQ_W = 41
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  vps_pkg::vps_post_ctl_t  ctl,
    input  logic signed [DOT_W-1:0] dot,
    input  logic [SQ_W-1:0]         sum_a,
    input  logic [SQ_W-1:0]         sum_b,
    input  logic [DSQ_W-1:0]        sum_d,
    output logic                    done,
    output logic [SQ_W-1:0]         dist_root,
    output logic [SQ_W-1:0]         len_a,
    output logic [SQ_W-1:0]         len_b,
    output logic signed [vps_pkg::COS_FIELD_W-1:0] cosine
);

    localparam int PRD_W      = 2 * SQ_W;
    localparam int MUL_CNT_W  = $clog2(SQ_W + 1);
    localparam int DV_W       = ((DOT_W > SQ_W) ? DOT_W : SQ_W) + 2;
    localparam int Q_W        = vps_pkg::COS_FIELD_W + 1;
    localparam int FRAC_CNT_W = $clog2(vps_pkg::COS_FRAC_BITS + 1);

    // root unit operand select
    localparam logic [1:0] RS_DEN   = 2'd0;
    localparam logic [1:0] RS_DIST  = 2'd1;
    localparam logic [1:0] RS_LEN_A = 2'd2;
    localparam logic [1:0] RS_LEN_B = 2'd3;

    typedef enum logic [6:0] {
        P_IDLE   = 7'b0000001,
        P_MUL    = 7'b0000010,
        P_RSTART = 7'b0000100,
        P_RWAIT  = 7'b0001000,
        P_DIV0   = 7'b0010000,
        P_DIV    = 7'b0100000,
        P_DONE   = 7'b1000000
    } post_state_t;

    post_state_t state_reg, state_next;

    logic [PRD_W-1:0]      mcand_reg;
    logic [SQ_W-1:0]       mplier_reg;
    logic [PRD_W-1:0]      prod_reg;
    logic [MUL_CNT_W-1:0]  mul_cnt_reg;
    logic [1:0]            root_sel_reg;
    logic [SQ_W-1:0]       den_reg;
    logic [SQ_W-1:0]       dist_reg;
    logic [SQ_W-1:0]       len_a_reg;
    logic [SQ_W-1:0]       len_b_reg;
    logic [DV_W-1:0]       rem_reg;
    logic [Q_W-1:0]        q_reg;
    logic [FRAC_CNT_W-1:0] frac_cnt_reg;
    logic                  neg_reg;

    logic [PRD_W-1:0]      radicand;
    logic                  root_start;
    logic                  root_done;
    logic [SQ_W-1:0]       root;

    logic signed [DV_W-1:0] dot_x;
    logic [DV_W-1:0]       mag;
    logic [DV_W-1:0]       den_x;
    logic [DV_W-1:0]       twice;
    logic                  fbit;
    logic                  zero_vec;
    logic                  over;
    logic [Q_W-1:0]        q_clip;
    logic [Q_W-1:0]        cos_q;

    // shared root unit
    vps_isqrt #(
        .RT_W  (SQ_W),
        .RAD_W (PRD_W)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    assign root_start = (state_reg == P_RSTART);

    always_comb begin
        unique case (root_sel_reg)
            RS_DEN:   radicand = prod_reg;
            RS_DIST:  radicand = PRD_W'(sum_d);
            RS_LEN_A: radicand = PRD_W'(sum_a);
            default:  radicand = PRD_W'(sum_b);
        endcase
    end

    // divider operands
    assign dot_x    = DV_W'(dot);
    assign mag      = dot_x[DV_W-1] ? -dot_x : dot_x;
    assign den_x    = DV_W'(den_reg);
    assign twice    = {rem_reg[DV_W-2:0], 1'b0};
    assign fbit     = twice >= den_x;
    assign zero_vec = (sum_a == '0) || (sum_b == '0);
    assign over     = mag >= (den_x << 1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE:   if (ctl.start) state_next = P_MUL;
            P_MUL:    if (mul_cnt_reg == MUL_CNT_W'(1)) state_next = P_RSTART;
            P_RSTART: state_next = P_RWAIT;
            P_RWAIT: begin
                if (root_done) begin
                    state_next = (root_sel_reg == RS_LEN_B) ? P_DIV0 : P_RSTART;
                end
            end
            P_DIV0:   state_next = (zero_vec || over) ? P_DONE : P_DIV;
            P_DIV:    if (frac_cnt_reg == FRAC_CNT_W'(1)) state_next = P_DONE;
            P_DONE:   if (ctl.ack) state_next = P_IDLE;
            default:  state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            P_IDLE: begin
                if (ctl.start) begin
                    mcand_reg    <= PRD_W'(sum_a);
                    mplier_reg   <= sum_b;
                    prod_reg     <= '0;
                    mul_cnt_reg  <= MUL_CNT_W'(SQ_W);
                    root_sel_reg <= RS_DEN;
                end
            end
            P_MUL: begin
                // shift-add product sa*sb, one bit per cycle
                if (mplier_reg[0]) prod_reg <= prod_reg + mcand_reg;
                mcand_reg   <= mcand_reg << 1;
                mplier_reg  <= mplier_reg >> 1;
                mul_cnt_reg <= mul_cnt_reg - 1'b1;
            end
            P_RWAIT: begin
                if (root_done) begin
                    unique case (root_sel_reg)
                        RS_DEN:   den_reg   <= root;
                        RS_DIST:  dist_reg  <= root;
                        RS_LEN_A: len_a_reg <= root;
                        default:  len_b_reg <= root;
                    endcase
                    root_sel_reg <= root_sel_reg + 1'b1;
                end
            end
            P_DIV0: begin
                neg_reg      <= dot_x[DV_W-1];
                frac_cnt_reg <= FRAC_CNT_W'(vps_pkg::COS_FRAC_BITS);
                if (zero_vec) begin
                    q_reg <= '0;
                end else if (over) begin
                    q_reg <= vps_pkg::COS_SAT;
                end else if (mag >= den_x) begin
                    q_reg   <= Q_W'(1);
                    rem_reg <= mag - den_x;
                end else begin
                    q_reg   <= '0;
                    rem_reg <= mag;
                end
            end
            P_DIV: begin
                // one fraction bit per cycle
                rem_reg      <= fbit ? twice - den_x : twice;
                q_reg        <= {q_reg[Q_W-2:0], fbit};
                frac_cnt_reg <= frac_cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    // clip and sign the quotient
    always_comb begin
        if (neg_reg) begin
            q_clip = (q_reg > vps_pkg::COS_NEG_MAX) ? vps_pkg::COS_NEG_MAX : q_reg;
            cos_q  = -q_clip;
        end else begin
            q_clip = (q_reg > vps_pkg::COS_POS_MAX) ? vps_pkg::COS_POS_MAX : q_reg;
            cos_q  = q_clip;
        end
    end

    assign cosine    = signed'(cos_q[vps_pkg::COS_FIELD_W-1:0]);
    assign done      = (state_reg == P_DONE);
    assign dist_root = dist_reg;
    assign len_a     = len_a_reg;
    assign len_b     = len_b_reg;

endmodule

// ----- rtl/vps_checker.sv -----
// ----------------------------------------------------------------------------
// vps_checker
// Port-level checks of the vector pair similarity block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vps_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input vps_pkg::vps_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input vps_pkg::vps_out_t m_data
);

    // a stalled result beat stays put
    `VPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // reset leaves no result pending and the input side open
    `VPS_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid && s_ready)

    // a taken beat leaves the input side closed in the next cycle
    `VPS_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind vector_pair_similarity vps_checker u_vps_checker (.*);

// ----- tb/vector_pair_similarity_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_pair_similarity_tb
// Drives element-pair vectors into the similarity block with random idle
// cycles on both channels and checks every result beat field by field.
// The checker predicts the dot product, roots and q1.15 cosine per vector.
// ----------------------------------------------------------------------------
module vector_pair_similarity_tb;

    localparam int VEC_MAX      = 256;
    localparam int ELEM_W       = vps_pkg::ELEM_FIELD_W;
    localparam int TOTAL_PAIRS  = 1150;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE_WAIT  = 300;
    localparam int LONG_HOLD    = 1500;
    localparam int PRINT_CAP    = 40;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

    // how the second vector relates to the first
    typedef enum int {
        PAIR_FREE,
        PAIR_SAME,
        PAIR_NEGATED,
        PAIR_NEAR,
        PAIR_A_ZERO,
        PAIR_B_ZERO,
        PAIR_EXTREME
    } pairing_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    vps_pkg::vps_in_t   s_data;
    logic               m_valid;
    logic               m_ready;
    vps_pkg::vps_out_t  m_data;

    // predictor state for the vector in flight
    longint             dot_sum;
    bit [63:0]          sq_sum_a;
    bit [63:0]          sq_sum_b;
    bit [63:0]          sq_sum_diff;
    int                 pairs_in_vec;
    bit                 vec_too_long;
    vps_pkg::vps_out_t  pending_scores[$];

    int  pairs_sent;
    int  vectors_done;
    int  rx_beats;
    int  mismatches;
    int  cycle_count;
    int  rx_hold_req;
    bit  tx_eager;
    bit  rx_eager;

    vector_pair_similarity #(
        .MAX_LEN   (VEC_MAX),
        .ELEM_BITS (ELEM_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_scores.size());
            $display("tb: failure");
            $finish;
        end
    end

    // floor square root, bit by bit from the top
    function automatic bit [63:0] floor_root(input bit [127:0] n);
        bit [63:0]  r;
        bit [63:0]  t;
        bit [127:0] t_sq;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            t = r | (64'd1 << k);
            t_sq = {64'd0, t} * {64'd0, t};
            if (t_sq <= n) r = t;
        end
        return r;
    endfunction

    // accumulate one accepted pair, queue the expected result on the last one
    function automatic void accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                            input logic signed [ELEM_W-1:0] b,
                                            input logic is_last);
        longint             sa;
        longint             sb;
        longint             d;
        bit [127:0]         prod;
        bit [63:0]          den;
        bit [63:0]          mag;
        bit [63:0]          ip;
        bit [63:0]          rem;
        bit [63:0]          q;
        bit [63:0]          root;
        bit                 neg;
        bit                 step_bit;
        vps_pkg::vps_out_t  res;
        sa = a;
        sb = b;
        if (pairs_in_vec < VEC_MAX) begin
            d = sa - sb;
            dot_sum     += sa * sb;
            sq_sum_a    += sa * sa;
            sq_sum_b    += sb * sb;
            sq_sum_diff += d * d;
            pairs_in_vec++;
        end else begin
            vec_too_long = 1'b1;
        end
        if (!is_last) return;

        // q1.15 cosine by restoring division against the floored root
        q = '0;
        if (sq_sum_a != 0 && sq_sum_b != 0) begin
            prod = {64'd0, sq_sum_a} * {64'd0, sq_sum_b};
            den  = floor_root(prod);
            neg  = dot_sum < 0;
            mag  = neg ? -dot_sum : dot_sum;
            ip   = mag / den;
            rem  = mag % den;
            if (ip >= 2) begin
                q = 64'(vps_pkg::COS_SAT);
            end else begin
                q = ip;
                for (int k = 0; k < vps_pkg::COS_FRAC_BITS; k++) begin
                    step_bit = rem >= den - rem;
                    rem = step_bit ? rem - (den - rem) : rem << 1;
                    q = {q[62:0], step_bit};
                end
            end
            if (neg) begin
                if (q > 64'(vps_pkg::COS_NEG_MAX)) q = 64'(vps_pkg::COS_NEG_MAX);
                q = -q;
            end else if (q > 64'(vps_pkg::COS_POS_MAX)) begin
                q = 64'(vps_pkg::COS_POS_MAX);
            end
        end

        res.dot_product = dot_sum[vps_pkg::DOT_FIELD_W-1:0];
        root = floor_root({64'd0, sq_sum_diff});
        res.distance = root[vps_pkg::ROOT_FIELD_W-1:0];
        root = floor_root({64'd0, sq_sum_a});
        res.length_a = root[vps_pkg::ROOT_FIELD_W-1:0];
        root = floor_root({64'd0, sq_sum_b});
        res.length_b = root[vps_pkg::ROOT_FIELD_W-1:0];
        res.cosine   = q[vps_pkg::COS_FIELD_W-1:0];
        res.overflow = vec_too_long;
        pending_scores.push_back(res);

        dot_sum      = 0;
        sq_sum_a     = '0;
        sq_sum_b     = '0;
        sq_sum_diff  = '0;
        pairs_in_vec = 0;
        vec_too_long = 1'b0;
        vectors_done++;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t, result %0d: %s", $time, rx_beats, what);
        mismatches++;
    endtask

    // one input beat: optional idle gap, then hold valid until accepted
    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b,
                             input logic is_last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{a_elem: a, b_elem: b, last: is_last};
        do @(posedge aclk); while (!s_ready);
        accumulate_pair(a, b, is_last);
        pairs_sent++;
        @(negedge aclk);
    endtask

    // sender stops until every pending result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_scores.size() != 0);
    endtask

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return ELEM_MAX;
                    1: return ELEM_MIN;
                    2: return ELEM_W'(0);
                    3: return ELEM_W'(1);
                    default: return ELEM_W'(-1);
                endcase
            end
            1: return ELEM_W'(int'($urandom_range(0, 16)) - 8);
            default: return ELEM_W'($urandom());
        endcase
    endfunction

    task automatic send_vector(input int len, input pairing_t pairing);
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            a = rand_elem();
            b = rand_elem();
            case (pairing)
                PAIR_SAME:    b = a;
                PAIR_NEGATED: b = -a;
                PAIR_NEAR:    b = ELEM_W'(int'(a) + int'($urandom_range(0, 6)) - 3);
                PAIR_A_ZERO:  a = '0;
                PAIR_B_ZERO:  b = '0;
                PAIR_EXTREME: begin
                    a = $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
                    b = $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
                end
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    // corner vectors: full scale, zero vectors, clipped cosine, widest distance
    task automatic test_directed_corners();
        // equal full-scale vectors, cosine clips at the top
        send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
        send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
        // opposite full-scale vectors, cosine clips at the bottom
        send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
        send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
        // zero first vector, zero second vector, both zero
        send_pair(16'sd0, 16'sd123, 1'b0);
        send_pair(16'sd0, -16'sd5, 1'b1);
        send_pair(16'sd77, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        // floored root pushes the ratio up to one
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, 16'sd2, 1'b1);
        // orthogonal vectors
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        // widest difference on the first two pairs
        send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
        send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
        send_pair(-16'sd1, 16'sd1, 1'b1);
        // small mixed values, cosine well inside range
        send_pair(16'sd3, -16'sd4, 1'b0);
        send_pair(-16'sd2, 16'sd5, 1'b1);
        drain_results();
    endtask

    // vectors at, one past and well past the length limit
    task automatic test_long_vectors();
        send_vector(VEC_MAX, PAIR_EXTREME);
        send_vector(VEC_MAX + 1, PAIR_FREE);
        send_vector(VEC_MAX + $urandom_range(2, 12), PAIR_SAME);
        drain_results();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_stall();
        rx_hold_req = LONG_HOLD;
        repeat (8) send_vector($urandom_range(2, 4), pairing_t'($urandom_range(0, PAIR_EXTREME)));
        drain_results();
    endtask

    // back-to-back beats on both channels
    task automatic test_no_idle_burst();
        tx_eager = 1'b1;
        rx_eager = 1'b1;
        repeat (6) send_vector($urandom_range(1, 10), pairing_t'($urandom_range(0, PAIR_EXTREME)));
        drain_results();
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // random lengths and pairings, with occasional pauses and idle-free stretches
    task automatic test_random_vectors();
        int roll;
        int len;
        while (pairs_sent < TOTAL_PAIRS) begin
            roll = $urandom_range(0, 19);
            if (roll < 16)      len = $urandom_range(1, 8);
            else if (roll < 19) len = $urandom_range(9, 40);
            else                len = $urandom_range(41, VEC_MAX);
            // keep the total close to the planned pair count
            if (len > TOTAL_PAIRS - pairs_sent) len = TOTAL_PAIRS - pairs_sent;
            tx_eager = ($urandom_range(0, 7) == 0);
            rx_eager = ($urandom_range(0, 7) == 0);
            send_vector(len, pairing_t'($urandom_range(0, PAIR_EXTREME)));
            if ($urandom_range(0, 9) == 0) drain_results();
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        drain_results();
    endtask

    // receiver: random wait before each result beat, long hold on request
    initial begin
        int wait_left;
        int seen;
        m_ready   = 1'b0;
        seen      = 0;
        wait_left = $urandom_range(0, 9);
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_beats != seen) begin
                seen = rx_beats;
                wait_left = rx_eager ? 0 : $urandom_range(0, 9);
            end
            if (rx_hold_req != 0) begin
                wait_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (wait_left > 0) begin
                m_ready <= 1'b0;
                wait_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker: each accepted beat against the oldest expectation
    always @(posedge aclk) begin
        vps_pkg::vps_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_scores.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = pending_scores.pop_front();
                if (m_data.dot_product !== want.dot_product)
                    report_mismatch($sformatf("dot_product got %0d want %0d",
                                              m_data.dot_product, want.dot_product));
                if (m_data.distance !== want.distance)
                    report_mismatch($sformatf("distance got %0d want %0d",
                                              m_data.distance, want.distance));
                if (m_data.length_a !== want.length_a)
                    report_mismatch($sformatf("length_a got %0d want %0d",
                                              m_data.length_a, want.length_a));
                if (m_data.length_b !== want.length_b)
                    report_mismatch($sformatf("length_b got %0d want %0d",
                                              m_data.length_b, want.length_b));
                if (m_data.cosine !== want.cosine)
                    report_mismatch($sformatf("cosine got %0d want %0d",
                                              m_data.cosine, want.cosine));
                if (m_data.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow got %0b want %0b",
                                              m_data.overflow, want.overflow));
            end
            rx_beats++;
        end
    end

    // test sequence
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        dot_sum      = 0;
        sq_sum_a     = '0;
        sq_sum_b     = '0;
        sq_sum_diff  = '0;
        pairs_in_vec = 0;
        vec_too_long = 1'b0;
        pairs_sent   = 0;
        vectors_done = 0;
        rx_beats     = 0;
        mismatches   = 0;
        cycle_count  = 0;
        rx_hold_req  = 0;
        tx_eager     = 1'b0;
        rx_eager     = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_corners();
        test_long_vectors();
        test_output_stall();
        test_no_idle_burst();
        test_random_vectors();

        // let any stray beat show up before the verdict
        repeat (SETTLE_WAIT) @(negedge aclk);
        $display("covered %0d pairs in %0d vectors: corners, over-length, long output stall,",
                 pairs_sent, vectors_done);
        $display("back-to-back and random traffic; %0d results checked, %0d mismatches",
                 rx_beats, mismatches);
        if (mismatches == 0 && pending_scores.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vps_pkg.sv
rtl/vps_mac.sv
rtl/vps_isqrt.sv
rtl/vps_post.sv
rtl/vector_pair_similarity.sv
rtl/vps_checker.sv
tb/vector_pair_similarity_tb.sv
